[hw/rtl/pt_pkg.sv]
// ----------------------------------------------------------------------------
// pt_pkg
// Shared types and sizes for the piece table text buffer core.
// ----------------------------------------------------------------------------
package pt_pkg;

    localparam int MaxPieces  = 64;
    localparam int PieceIdxW  = 6;
    localparam int PieceCntW  = 7;
    localparam int StoreDepth = 4096;
    localparam int StoreAddrW = 12;
    localparam int FillW      = 13;
    localparam int PosW       = 14;
    localparam int MaxRead    = 64;
    localparam int ReadCntW   = 7;
    localparam int ByteW      = 8;
    localparam int InTdataW   = 40;
    localparam int OutTdataW  = 32;

    typedef enum logic [2:0] {
        REQ_LOAD       = 3'd0,
        REQ_INSERT     = 3'd1,
        REQ_ERASE      = 3'd2,
        REQ_READ_ONE   = 3'd3,
        REQ_READ_RANGE = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_TABLE = 2'd2,
        ST_STORE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOC_RD,
        S_LOC_CMP,
        S_DECIDE,
        S_SH_RD,
        S_SH_WR,
        S_WR,
        S_BYTE_RD,
        S_BYTE_CAP,
        S_EMIT,
        S_NXT_RD,
        S_NXT_CAP
    } state_t;

    typedef struct packed {
        logic                  app;
        logic [StoreAddrW-1:0] start;
        logic [FillW-1:0]      len;
    } piece_t;

endpackage

[hw/rtl/pt_ram.sv]
// ----------------------------------------------------------------------------
// pt_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module pt_ram #(
    parameter int Depth = 64,
    parameter int Width = 8,
    localparam int AddrW = $clog2(Depth)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [Width-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [Width-1:0] rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/piece_table_text_buffer_core.sv]
// ----------------------------------------------------------------------------
// piece_table_text_buffer_core
// Piece table text buffer: original and add byte stores plus a piece list,
// all held in synchronous rams and walked by one sequencer.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one request beat; tlast ends a load or insert run.
//   m_ channel returns results; tlast marks the last result of a request.
//   load, non-final insert beats, unknown codes and out-of-range requests
//   answer straight from idle. edits and reads walk the piece list one
//   entry per read of the single piece ram read port; edits then shift the
//   tail one moved entry at a time and write up to 3 entries. a read range
//   fetches each further byte from its store, and first reads the next
//   piece entry on a piece change.
//   one request is worked at a time; the next beat is taken once the last
//   result sits in the output register, which frees the sequencer.
//   reset empties the document and clears the fill and piece counts; the rams need no
//   clearing pass since pieces only cover written entries.
//   a stalled receiver holds the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module piece_table_text_buffer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_type[2:0], offset[16:3], count[30:17], data_byte[38:31], zero[39]
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_byte[7:0], status[9:8], doc_length[23:10], pieces_in_use[30:24], zero[31]
    output logic [31:0] m_tdata,
    output logic        m_tlast
);

    pt_pkg::state_t  state_reg, state_next, route;

    logic [2:0]  in_req;
    logic [13:0] in_offset, in_count;
    logic [7:0]  in_byte;
    logic        s_acc;

    pt_pkg::req_t    op_reg, op_next;
    pt_pkg::status_t status_reg, status_next;
    logic [7:0]  byte_reg, byte_next;
    logic [6:0]  rd_left_reg, rd_left_next;
    logic [13:0] pos_reg, pos_next, cnt_reg, cnt_next;
    logic        phase_reg, phase_next;

    logic [6:0]  used_reg, used_next;
    logic [13:0] doclen_reg, doclen_next;
    logic [12:0] ofill_reg, ofill_next, afill_reg, afill_next;
    logic [13:0] ins_pos_reg, ins_pos_next;
    logic [12:0] run_start_reg, run_start_next;
    logic        run_active_reg, run_active_next;
    logic        run_failed_reg, run_failed_next;
    logic        load_open_reg, load_open_next;

    logic [6:0]  idx_reg, idx_next;
    logic [13:0] acc_reg, acc_next, target_reg, target_next;
    logic [12:0] inner_reg, inner_next;
    pt_pkg::piece_t ent_reg, ent_next;

    logic [6:0]  si_reg, si_next;
    logic [12:0] sin_reg, sin_next;
    pt_pkg::piece_t sent_reg, sent_next;

    logic [6:0]  sh_src_reg, sh_src_next, sh_left_reg, sh_left_next;
    logic [6:0]  sh_delta_reg, sh_delta_next;
    logic        sh_desc_reg, sh_desc_next;

    pt_pkg::piece_t wq_data_reg [3];
    pt_pkg::piece_t wq_data_next [3];
    logic [5:0]  wq_addr_reg [3];
    logic [5:0]  wq_addr_next [3];
    logic [1:0]  wq_n_reg, wq_n_next, wq_k_reg, wq_k_next;
    logic [6:0]  fin_used_reg, fin_used_next;
    logic [13:0] fin_len_reg, fin_len_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [13:0] out_len_reg, out_len_next;
    logic [6:0]  out_used_reg, out_used_next;
    logic        out_last_reg, out_last_next;

    logic        pt_we;
    logic [5:0]  pt_waddr, pt_raddr;
    pt_pkg::piece_t pt_wdata, pt_rdata;
    logic        orig_we, app_we;
    logic [11:0] orig_waddr, app_waddr, st_raddr;
    logic [7:0]  orig_rdata, app_rdata;

    logic [13:0] loc_sum;
    logic        loc_hit, loc_end, out_free, rd_more;

    assign in_req    = s_tdata[2:0];
    assign in_offset = s_tdata[16:3];
    assign in_count  = s_tdata[30:17];
    assign in_byte   = s_tdata[38:31];
    assign s_tready  = (state_reg == pt_pkg::S_IDLE);
    assign s_acc     = s_tvalid && s_tready;

    assign loc_sum  = acc_reg + {1'b0, pt_rdata.len};
    assign loc_hit  = target_reg < loc_sum;
    assign loc_end  = idx_reg == used_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign rd_more  = (op_reg == pt_pkg::REQ_READ_RANGE) && (rd_left_reg > 7'd1);

    pt_ram #(.Depth(pt_pkg::MaxPieces), .Width($bits(pt_pkg::piece_t))) u_piece_ram (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    pt_ram #(.Depth(pt_pkg::StoreDepth), .Width(pt_pkg::ByteW)) u_orig_ram (
        .aclk  (aclk),
        .we    (orig_we),
        .waddr (orig_waddr),
        .wdata (in_byte),
        .raddr (st_raddr),
        .rdata (orig_rdata)
    );

    pt_ram #(.Depth(pt_pkg::StoreDepth), .Width(pt_pkg::ByteW)) u_app_ram (
        .aclk  (aclk),
        .we    (app_we),
        .waddr (app_waddr),
        .wdata (in_byte),
        .raddr (st_raddr),
        .rdata (app_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pt_pkg::S_IDLE:     if (s_acc) state_next = route;
            pt_pkg::S_LOC_RD:   state_next = loc_end ? pt_pkg::S_DECIDE : pt_pkg::S_LOC_CMP;
            pt_pkg::S_LOC_CMP:  state_next = loc_hit ? pt_pkg::S_DECIDE : pt_pkg::S_LOC_RD;
            pt_pkg::S_DECIDE:   state_next = route;
            pt_pkg::S_SH_RD:    state_next = (sh_left_reg == 7'd0) ? pt_pkg::S_WR
                                                                   : pt_pkg::S_SH_WR;
            pt_pkg::S_SH_WR:    state_next = pt_pkg::S_SH_RD;
            pt_pkg::S_WR:       if (wq_k_reg == wq_n_reg) state_next = pt_pkg::S_EMIT;
            pt_pkg::S_BYTE_RD:  state_next = pt_pkg::S_BYTE_CAP;
            pt_pkg::S_BYTE_CAP: state_next = pt_pkg::S_EMIT;
            pt_pkg::S_EMIT:     if (out_free) state_next = route;
            pt_pkg::S_NXT_RD:   state_next = pt_pkg::S_NXT_CAP;
            pt_pkg::S_NXT_CAP:  state_next = pt_pkg::S_BYTE_RD;
            default:            state_next = pt_pkg::S_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        logic [6:0]  lo_used;
        logic [13:0] lo_len;
        logic [12:0] lo_ofill, lo_afill, ofill_inc;
        logic [12:0] rs_eff, af_eff, run_n;
        logic [13:0] insp_eff, rem, clamp;
        logic [6:0]  clamp64;
        logic        fail_eff;
        logic [7:0]  need, nu;
        logic        has_l, has_r, do_shift;
        logic [6:0]  ei2, sh_from, sh_to;
        logic [1:0]  nr;
        pt_pkg::piece_t new_pc, lpc, rpc;
        logic [6:0]  dst;

        route           = pt_pkg::S_IDLE;
        op_next         = op_reg;
        status_next     = status_reg;
        byte_next       = byte_reg;
        rd_left_next    = rd_left_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        phase_next      = phase_reg;
        used_next       = used_reg;
        doclen_next     = doclen_reg;
        ofill_next      = ofill_reg;
        afill_next      = afill_reg;
        ins_pos_next    = ins_pos_reg;
        run_start_next  = run_start_reg;
        run_active_next = run_active_reg;
        run_failed_next = run_failed_reg;
        load_open_next  = load_open_reg;
        idx_next        = idx_reg;
        acc_next        = acc_reg;
        target_next     = target_reg;
        inner_next      = inner_reg;
        ent_next        = ent_reg;
        si_next         = si_reg;
        sin_next        = sin_reg;
        sent_next       = sent_reg;
        sh_src_next     = sh_src_reg;
        sh_left_next    = sh_left_reg;
        sh_delta_next   = sh_delta_reg;
        sh_desc_next    = sh_desc_reg;
        wq_data_next    = wq_data_reg;
        wq_addr_next    = wq_addr_reg;
        wq_n_next       = wq_n_reg;
        wq_k_next       = wq_k_reg;
        fin_used_next   = fin_used_reg;
        fin_len_next    = fin_len_reg;
        m_tvalid_next   = m_tready ? 1'b0 : m_tvalid_reg;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        out_used_next   = out_used_reg;
        out_last_next   = out_last_reg;
        pt_we      = 1'b0;
        pt_waddr   = '0;
        pt_wdata   = '0;
        pt_raddr   = '0;
        orig_we    = 1'b0;
        orig_waddr = '0;
        app_we     = 1'b0;
        app_waddr  = '0;
        st_raddr   = ent_reg.start + inner_reg[11:0];

        lo_used   = load_open_reg ? used_reg : 7'd0;
        lo_len    = load_open_reg ? doclen_reg : 14'd0;
        lo_ofill  = load_open_reg ? ofill_reg : 13'd0;
        lo_afill  = load_open_reg ? afill_reg : 13'd0;
        ofill_inc = lo_ofill + 13'd1;
        rs_eff    = run_active_reg ? run_start_reg : afill_reg;
        insp_eff  = run_active_reg ? ins_pos_reg : in_offset;
        fail_eff  = run_active_reg && run_failed_reg;
        af_eff    = afill_reg;
        rem       = doclen_reg - in_offset;
        clamp     = (in_count > rem) ? rem : in_count;
        clamp64   = (clamp > 14'(pt_pkg::MaxRead)) ? 7'(pt_pkg::MaxRead) : clamp[6:0];
        run_n     = afill_reg - run_start_reg;
        new_pc    = '{app: 1'b1, start: run_start_reg[11:0], len: run_n};
        need      = (inner_reg != 13'd0) ? 8'd2 : 8'd1;
        has_l     = sin_reg != 13'd0;
        has_r     = (idx_reg < used_reg) && (inner_reg != 13'd0);
        ei2       = idx_reg + {6'd0, has_r};
        nr        = {1'b0, has_l} + {1'b0, has_r};
        nu        = {1'b0, used_reg} - ({1'b0, ei2} - {1'b0, si_reg}) + {6'd0, nr};
        lpc       = '{app: sent_reg.app, start: sent_reg.start, len: sin_reg};
        rpc       = '{app: ent_reg.app, start: ent_reg.start + inner_reg[11:0],
                      len: ent_reg.len - inner_reg};
        do_shift  = 1'b0;
        sh_from   = '0;
        sh_to     = '0;
        dst       = sh_src_reg + sh_delta_reg;

        unique case (state_reg)
            pt_pkg::S_IDLE: begin
                route = pt_pkg::S_EMIT;
                if (s_acc) begin
                    op_next      = pt_pkg::req_t'(in_req);
                    status_next  = pt_pkg::ST_OK;
                    byte_next    = '0;
                    rd_left_next = '0;
                    idx_next     = '0;
                    acc_next     = '0;
                    target_next  = in_offset;
                    unique case (pt_pkg::req_t'(in_req))
                        pt_pkg::REQ_LOAD: begin
                            afill_next     = lo_afill;
                            load_open_next = !s_tlast;
                            if (!load_open_reg) begin
                                run_active_next = 1'b0;
                                run_failed_next = 1'b0;
                            end
                            if (!lo_ofill[12]) begin
                                orig_we     = 1'b1;
                                orig_waddr  = lo_ofill[11:0];
                                ofill_next  = ofill_inc;
                                pt_we       = 1'b1;
                                pt_waddr    = '0;
                                pt_wdata    = '{app: 1'b0, start: '0, len: ofill_inc};
                                used_next   = 7'd1;
                                doclen_next = {1'b0, ofill_inc};
                            end else begin
                                status_next = pt_pkg::ST_STORE;
                                ofill_next  = lo_ofill;
                                used_next   = lo_used;
                                doclen_next = lo_len;
                            end
                        end
                        pt_pkg::REQ_INSERT: begin
                            load_open_next = 1'b0;
                            if (!afill_reg[12]) begin
                                app_we    = 1'b1;
                                app_waddr = afill_reg[11:0];
                                af_eff    = afill_reg + 13'd1;
                            end else begin
                                fail_eff    = 1'b1;
                                status_next = pt_pkg::ST_STORE;
                            end
                            run_start_next = rs_eff;
                            ins_pos_next   = insp_eff;
                            afill_next     = af_eff;
                            if (!s_tlast) begin
                                run_active_next = 1'b1;
                                run_failed_next = fail_eff;
                            end else begin
                                run_active_next = 1'b0;
                                run_failed_next = 1'b0;
                                if (fail_eff) begin
                                    afill_next  = rs_eff;
                                    status_next = pt_pkg::ST_STORE;
                                end else if (used_reg == 7'd0 || insp_eff >= doclen_reg) begin
                                    if (used_reg >= 7'(pt_pkg::MaxPieces)) begin
                                        afill_next  = rs_eff;
                                        status_next = pt_pkg::ST_TABLE;
                                    end else begin
                                        wq_addr_next[0] = used_reg[5:0];
                                        wq_data_next[0] = '{app: 1'b1, start: rs_eff[11:0],
                                                            len: af_eff - rs_eff};
                                        wq_n_next     = 2'd1;
                                        wq_k_next     = 2'd0;
                                        fin_used_next = used_reg + 7'd1;
                                        fin_len_next  = doclen_reg + {1'b0, af_eff - rs_eff};
                                        route         = pt_pkg::S_WR;
                                    end
                                end else begin
                                    target_next = insp_eff;
                                    route       = pt_pkg::S_LOC_RD;
                                end
                            end
                        end
                        pt_pkg::REQ_ERASE: begin
                            load_open_next = 1'b0;
                            if (in_offset >= doclen_reg) begin
                                status_next = pt_pkg::ST_RANGE;
                            end else if (clamp != 14'd0) begin
                                cnt_next   = clamp;
                                pos_next   = in_offset;
                                phase_next = 1'b0;
                                route      = pt_pkg::S_LOC_RD;
                            end
                        end
                        pt_pkg::REQ_READ_ONE, pt_pkg::REQ_READ_RANGE: begin
                            load_open_next = 1'b0;
                            if (in_offset >= doclen_reg) begin
                                status_next = pt_pkg::ST_RANGE;
                            end else if (in_req == pt_pkg::REQ_READ_ONE) begin
                                rd_left_next = 7'd1;
                                route        = pt_pkg::S_LOC_RD;
                            end else if (clamp64 != 7'd0) begin
                                rd_left_next = clamp64;
                                route        = pt_pkg::S_LOC_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            pt_pkg::S_LOC_RD: begin
                if (loc_end) begin
                    inner_next = '0;
                end else begin
                    pt_raddr = idx_reg[5:0];
                end
            end
            pt_pkg::S_LOC_CMP: begin
                if (loc_hit) begin
                    inner_next = 13'(target_reg - acc_reg);
                    ent_next   = pt_rdata;
                end else begin
                    acc_next = loc_sum;
                    idx_next = idx_reg + 7'd1;
                end
            end
            pt_pkg::S_DECIDE: begin
                route = pt_pkg::S_EMIT;
                unique case (op_reg)
                    pt_pkg::REQ_INSERT: begin
                        if ({1'b0, used_reg} + need > 8'(pt_pkg::MaxPieces)) begin
                            afill_next  = run_start_reg;
                            status_next = pt_pkg::ST_TABLE;
                        end else begin
                            do_shift      = 1'b1;
                            fin_used_next = used_reg + need[6:0];
                            fin_len_next  = doclen_reg + {1'b0, run_n};
                            wq_k_next     = 2'd0;
                            if (inner_reg == 13'd0) begin
                                sh_from         = idx_reg;
                                sh_to           = idx_reg + 7'd1;
                                wq_addr_next[0] = idx_reg[5:0];
                                wq_data_next[0] = new_pc;
                                wq_n_next       = 2'd1;
                            end else begin
                                sh_from         = idx_reg + 7'd1;
                                sh_to           = idx_reg + 7'd3;
                                wq_addr_next[0] = idx_reg[5:0];
                                wq_data_next[0] = '{app: ent_reg.app, start: ent_reg.start,
                                                    len: inner_reg};
                                wq_addr_next[1] = idx_reg[5:0] + 6'd1;
                                wq_data_next[1] = new_pc;
                                wq_addr_next[2] = idx_reg[5:0] + 6'd2;
                                wq_data_next[2] = rpc;
                                wq_n_next       = 2'd3;
                            end
                            route = pt_pkg::S_SH_RD;
                        end
                    end
                    pt_pkg::REQ_ERASE: begin
                        if (!phase_reg) begin
                            si_next     = idx_reg;
                            sin_next    = inner_reg;
                            sent_next   = ent_reg;
                            target_next = pos_reg + cnt_reg;
                            phase_next  = 1'b1;
                            idx_next    = '0;
                            acc_next    = '0;
                            route       = pt_pkg::S_LOC_RD;
                        end else if (nu > 8'(pt_pkg::MaxPieces)) begin
                            status_next = pt_pkg::ST_TABLE;
                        end else begin
                            do_shift        = 1'b1;
                            sh_from         = ei2;
                            sh_to           = si_reg + {5'd0, nr};
                            wq_addr_next[0] = si_reg[5:0];
                            wq_data_next[0] = has_l ? lpc : rpc;
                            wq_addr_next[1] = si_reg[5:0] + 6'd1;
                            wq_data_next[1] = rpc;
                            wq_n_next       = nr;
                            wq_k_next       = 2'd0;
                            fin_used_next   = nu[6:0];
                            fin_len_next    = doclen_reg - cnt_reg;
                            route           = pt_pkg::S_SH_RD;
                        end
                    end
                    pt_pkg::REQ_READ_ONE, pt_pkg::REQ_READ_RANGE: route = pt_pkg::S_BYTE_RD;
                    default: ;
                endcase
                if (do_shift) begin
                    sh_left_next  = used_reg - sh_from;
                    sh_desc_next  = sh_to > sh_from;
                    sh_src_next   = (sh_to > sh_from) ? used_reg - 7'd1 : sh_from;
                    sh_delta_next = sh_to - sh_from;
                end
            end
            pt_pkg::S_SH_RD: begin
                pt_raddr = sh_src_reg[5:0];
            end
            pt_pkg::S_SH_WR: begin
                pt_we        = 1'b1;
                pt_waddr     = dst[5:0];
                pt_wdata     = pt_rdata;
                sh_src_next  = sh_desc_reg ? sh_src_reg - 7'd1 : sh_src_reg + 7'd1;
                sh_left_next = sh_left_reg - 7'd1;
            end
            pt_pkg::S_WR: begin
                if (wq_k_reg != wq_n_reg) begin
                    pt_we     = 1'b1;
                    pt_waddr  = wq_addr_reg[wq_k_reg];
                    pt_wdata  = wq_data_reg[wq_k_reg];
                    wq_k_next = wq_k_reg + 2'd1;
                end else begin
                    used_next   = fin_used_reg;
                    doclen_next = fin_len_reg;
                    status_next = pt_pkg::ST_OK;
                end
            end
            pt_pkg::S_BYTE_RD: ;
            pt_pkg::S_BYTE_CAP: begin
                byte_next = ent_reg.app ? app_rdata : orig_rdata;
            end
            pt_pkg::S_EMIT: begin
                route = pt_pkg::S_IDLE;
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_byte_next   = byte_reg;
                    out_status_next = status_reg;
                    out_len_next    = doclen_reg;
                    out_used_next   = used_reg;
                    out_last_next   = !rd_more;
                    if (rd_more) begin
                        rd_left_next = rd_left_reg - 7'd1;
                        if (inner_reg + 13'd1 == ent_reg.len) begin
                            idx_next   = idx_reg + 7'd1;
                            inner_next = '0;
                            route      = pt_pkg::S_NXT_RD;
                        end else begin
                            inner_next = inner_reg + 13'd1;
                            route      = pt_pkg::S_BYTE_RD;
                        end
                    end
                end
            end
            pt_pkg::S_NXT_RD: begin
                pt_raddr = idx_reg[5:0];
            end
            pt_pkg::S_NXT_CAP: begin
                ent_next = pt_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pt_pkg::S_IDLE;
            used_reg       <= '0;
            doclen_reg     <= '0;
            ofill_reg      <= '0;
            afill_reg      <= '0;
            ins_pos_reg    <= '0;
            run_start_reg  <= '0;
            run_active_reg <= 1'b0;
            run_failed_reg <= 1'b0;
            load_open_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            doclen_reg     <= doclen_next;
            ofill_reg      <= ofill_next;
            afill_reg      <= afill_next;
            ins_pos_reg    <= ins_pos_next;
            run_start_reg  <= run_start_next;
            run_active_reg <= run_active_next;
            run_failed_reg <= run_failed_next;
            load_open_reg  <= load_open_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        status_reg     <= status_next;
        byte_reg       <= byte_next;
        rd_left_reg    <= rd_left_next;
        pos_reg        <= pos_next;
        cnt_reg        <= cnt_next;
        phase_reg      <= phase_next;
        idx_reg        <= idx_next;
        acc_reg        <= acc_next;
        target_reg     <= target_next;
        inner_reg      <= inner_next;
        ent_reg        <= ent_next;
        si_reg         <= si_next;
        sin_reg        <= sin_next;
        sent_reg       <= sent_next;
        sh_src_reg     <= sh_src_next;
        sh_left_reg    <= sh_left_next;
        sh_delta_reg   <= sh_delta_next;
        sh_desc_reg    <= sh_desc_next;
        wq_data_reg    <= wq_data_next;
        wq_addr_reg    <= wq_addr_next;
        wq_n_reg       <= wq_n_next;
        wq_k_reg       <= wq_k_next;
        fin_used_reg   <= fin_used_next;
        fin_len_reg    <= fin_len_next;
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
        out_used_reg   <= out_used_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_used_reg, out_len_reg, out_status_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the piece table text buffer core: a directed table
// of requests followed by random load, insert, erase, read and unknown-code traffic, with
// sender bursts, receiver stalls and a long receiver hold-off. Every result
// beat is compared against an in-bench model of the document.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pt_pkg::*;

    localparam int TimeoutCycles = 200000;

    typedef struct {
        logic [7:0]  rbyte;
        status_t     status;
        logic [13:0] dlen;
        logic [6:0]  npieces;
        logic        fin;
    } result_t;

    typedef struct {
        logic [2:0]  req;
        logic [13:0] offset;
        logic [13:0] count;
        logic [7:0]  data;
        logic        last;
        logic        has_exp;
        status_t     exp_status;
        logic [13:0] exp_dlen;
        logic [6:0]  exp_pieces;
    } row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    piece_table_text_buffer_core dut (.*);

    always #10 aclk = ~aclk;

    // document model
    logic        pc_app [MaxPieces];
    int          pc_start [MaxPieces];
    int          pc_len [MaxPieces];
    int          n_pieces, doc_len, orig_fill, add_fill, ins_pos, run_base;
    bit          run_on, load_on, run_bad;
    logic [7:0]  orig_mem [StoreDepth];
    logic [7:0]  add_mem [StoreDepth];

    result_t     pending [$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          hold_off = 0;

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int find_piece(int pos, output int inner);
        int acc;
        acc = 0;
        for (int i = 0; i < n_pieces; i++) begin
            if (pos < acc + pc_len[i]) begin
                inner = pos - acc;
                return i;
            end
            acc += pc_len[i];
        end
        inner = 0;
        return n_pieces;
    endfunction

    function automatic logic [7:0] char_at(int pos);
        int inner, i, a;
        i = find_piece(pos, inner);
        if (i >= n_pieces) return 8'd0;
        a = pc_start[i] + inner;
        return pc_app[i] ? add_mem[a] : orig_mem[a];
    endfunction

    function automatic void move_tail(int from, int to);
        int n;
        logic ta [MaxPieces];
        int   ts [MaxPieces];
        int   tl [MaxPieces];
        n = n_pieces - from;
        for (int k = 0; k < n; k++) begin
            ta[k] = pc_app[from+k]; ts[k] = pc_start[from+k]; tl[k] = pc_len[from+k];
        end
        for (int k = 0; k < n; k++) begin
            pc_app[to+k] = ta[k]; pc_start[to+k] = ts[k]; pc_len[to+k] = tl[k];
        end
    endfunction

    function automatic void put_piece(int i, logic app, int st, int len);
        pc_app[i] = app; pc_start[i] = st; pc_len[i] = len;
    endfunction

    function automatic status_t load_char(logic [7:0] b, logic last);
        status_t st;
        st = ST_OK;
        if (!load_on) begin
            n_pieces = 0; doc_len = 0; orig_fill = 0; add_fill = 0;
            run_on = 0; run_bad = 0;
        end
        if (orig_fill < StoreDepth) begin
            orig_mem[orig_fill] = b;
            orig_fill++;
            put_piece(0, 0, 0, orig_fill);
            n_pieces = 1;
            doc_len = orig_fill;
        end else st = ST_STORE;
        load_on = !last;
        return st;
    endfunction

    function automatic status_t insert_char(int pos, logic [7:0] b, logic last);
        status_t st;
        int n, inner, i, need, rs, rl;
        logic app;
        st = ST_OK;
        if (!run_on) begin
            run_on = 1; run_bad = 0; ins_pos = pos; run_base = add_fill;
        end
        if (add_fill < StoreDepth) begin
            add_mem[add_fill] = b;
            add_fill++;
        end else begin
            run_bad = 1;
            st = ST_STORE;
        end
        if (!last) return st;
        run_on = 0;
        if (run_bad) begin
            add_fill = run_base; run_bad = 0;
            return ST_STORE;
        end
        n = add_fill - run_base;
        if (n_pieces == 0 || ins_pos >= doc_len) begin
            if (n_pieces + 1 > MaxPieces) begin
                add_fill = run_base;
                return ST_TABLE;
            end
            put_piece(n_pieces, 1, run_base, n);
            n_pieces++;
        end else begin
            i = find_piece(ins_pos, inner);
            need = (inner == 0) ? 1 : 2;
            if (n_pieces + need > MaxPieces) begin
                add_fill = run_base;
                return ST_TABLE;
            end
            if (inner == 0) begin
                move_tail(i, i + 1);
                put_piece(i, 1, run_base, n);
            end else begin
                app = pc_app[i];
                rs = pc_start[i] + inner;
                rl = pc_len[i] - inner;
                move_tail(i + 1, i + 3);
                pc_len[i] = inner;
                put_piece(i + 1, 1, run_base, n);
                put_piece(i + 2, app, rs, rl);
            end
            n_pieces += need;
        end
        doc_len += n;
        return ST_OK;
    endfunction

    function automatic status_t erase_span(int pos, int cnt);
        int sin, ein, si, ei, nr, nu;
        logic ra [2];
        int   rs [2];
        int   rl [2];
        if (pos >= doc_len) return ST_RANGE;
        if (cnt > doc_len - pos) cnt = doc_len - pos;
        if (cnt == 0) return ST_OK;
        si = find_piece(pos, sin);
        ei = find_piece(pos + cnt, ein);
        nr = 0;
        if (sin > 0) begin
            ra[nr] = pc_app[si]; rs[nr] = pc_start[si]; rl[nr] = sin; nr++;
        end
        if (ei < n_pieces && ein > 0) begin
            ra[nr] = pc_app[ei]; rs[nr] = pc_start[ei] + ein; rl[nr] = pc_len[ei] - ein;
            nr++; ei++;
        end
        nu = n_pieces - (ei - si) + nr;
        if (nu > MaxPieces) return ST_TABLE;
        move_tail(ei, si + nr);
        for (int k = 0; k < nr; k++) put_piece(si + k, ra[k], rs[k], rl[k]);
        n_pieces = nu;
        doc_len -= cnt;
        return ST_OK;
    endfunction

    function automatic void queue_result(logic [7:0] b, status_t st, logic fin);
        result_t r;
        r.rbyte = b; r.status = st; r.dlen = doc_len[13:0];
        r.npieces = n_pieces[6:0]; r.fin = fin;
        pending.push_back(r);
    endfunction

    function automatic void apply_request(logic [2:0] req, int pos, int cnt,
                                          logic [7:0] b, logic last);
        if (req > 3'd4) begin
            queue_result(0, ST_OK, 1);
            return;
        end
        if (req == REQ_LOAD) begin
            queue_result(0, load_char(b, last), 1);
            return;
        end
        load_on = 0;
        if (req == REQ_INSERT) queue_result(0, insert_char(pos, b, last), 1);
        else if (req == REQ_ERASE) queue_result(0, erase_span(pos, cnt), 1);
        else if (pos >= doc_len) queue_result(0, ST_RANGE, 1);
        else if (req == REQ_READ_ONE) queue_result(char_at(pos), ST_OK, 1);
        else begin
            if (cnt > doc_len - pos) cnt = doc_len - pos;
            if (cnt > MaxRead) cnt = MaxRead;
            if (cnt == 0) queue_result(0, ST_OK, 1);
            else for (int k = 0; k < cnt; k++)
                queue_result(char_at(pos + k), ST_OK, k + 1 == cnt);
        end
    endfunction

    // sender
    task automatic send_beat(logic [2:0] req, logic [13:0] pos, logic [13:0] cnt,
                             logic [7:0] b, logic last);
        s_tdata  <= {1'b0, b, cnt, pos, req};
        s_tlast  <= last;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        apply_request(req, pos, cnt, b, last);
    endtask

    task automatic maybe_gap();
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic run_row(row_t r);
        status_t st;
        send_beat(r.req, r.offset, r.count, r.data, r.last);
        if (r.has_exp) begin
            st = pending[$].status;
            if (st != r.exp_status) report("table status", st, r.exp_status);
            if (pending[$].dlen != r.exp_dlen) report("table length", pending[$].dlen, r.exp_dlen);
            if (pending[$].npieces != r.exp_pieces)
                report("table pieces", pending[$].npieces, r.exp_pieces);
        end
    endtask

    row_t directed [] = '{
        '{REQ_READ_ONE,   0,     0,     0,     0, 1, ST_RANGE, 0, 0},
        '{REQ_ERASE,      0,     5,     0,     0, 1, ST_RANGE, 0, 0},
        '{REQ_READ_RANGE, 0,     5,     0,     0, 1, ST_RANGE, 0, 0},
        '{REQ_INSERT,     14'h3FFF, 0,  8'hFF, 1, 1, ST_OK,    1, 1},
        '{REQ_LOAD,       0,     0,     8'h00, 0, 1, ST_OK,    1, 1},
        '{REQ_LOAD,       0,     0,     8'hFF, 0, 1, ST_OK,    2, 1},
        '{REQ_LOAD,       0,     0,     8'h55, 0, 1, ST_OK,    3, 1},
        '{REQ_LOAD,       0,     0,     8'hAA, 1, 1, ST_OK,    4, 1},
        '{REQ_INSERT,     2,     0,     8'h11, 0, 1, ST_OK,    4, 1},
        '{REQ_INSERT,     0,     0,     8'h22, 1, 1, ST_OK,    6, 3},
        '{REQ_INSERT,     0,     0,     8'h33, 1, 0, ST_OK,    0, 0},
        '{REQ_INSERT,     14'h3FFF, 0,  8'h44, 1, 0, ST_OK,    0, 0},
        '{REQ_READ_RANGE, 0,     14'h3FFF, 0,  0, 0, ST_OK,    0, 0},
        '{REQ_READ_RANGE, 1,     0,     0,     0, 1, ST_OK,    8, 5},
        '{REQ_READ_ONE,   7,     0,     0,     0, 0, ST_OK,    0, 0},
        '{REQ_READ_ONE,   8,     0,     0,     0, 1, ST_RANGE, 8, 5},
        '{3'd5,           0,     0,     0,     0, 1, ST_OK,    8, 5},
        '{3'd7,           14'h3FFF, 14'h3FFF, 8'hFF, 1, 1, ST_OK, 8, 5},
        '{REQ_ERASE,      3,     0,     0,     0, 1, ST_OK,    8, 5},
        '{REQ_ERASE,      2,     3,     0,     0, 0, ST_OK,    0, 0},
        '{REQ_ERASE,      1,     14'h3FFF, 0,  0, 1, ST_OK,    1, 1},
        '{REQ_READ_RANGE, 0,     1,     0,     0, 0, ST_OK,    0, 0},
        '{REQ_ERASE,      0,     1,     0,     0, 1, ST_OK,    0, 0}
    };

    initial begin
        int items, n, base;
        logic [2:0] kind;
        n_pieces = 0; doc_len = 0; orig_fill = 0; add_fill = 0;
        run_on = 0; load_on = 0; run_bad = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (directed[i]) run_row(directed[i]);
        drain();
        // the sender waits here while the receiver holds off and the core stalls
        hold_off = 1;
        for (int k = 0; k < 4; k++) send_beat(REQ_LOAD, 0, 0, $urandom, k == 3);
        send_beat(REQ_READ_RANGE, 0, 10, 0, 0);
        send_beat(REQ_READ_ONE, 1, 0, 0, 0);
        drain();
        items = 0;
        while (items < 120) begin
            kind = $urandom_range(0, 9);
            base = doc_len + 2;
            if (kind == 0 && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 20);
                for (int k = 0; k < n; k++) begin
                    send_beat(REQ_LOAD, $urandom, $urandom, $urandom, k == n - 1);
                    maybe_gap();
                end
                items += n;
            end else if (kind <= 3) begin
                n = $urandom_range(1, 5);
                base = $urandom_range(0, base);
                if ($urandom_range(0, 15) == 0) base = $urandom_range(8000, 16383);
                for (int k = 0; k < n; k++) begin
                    send_beat(REQ_INSERT, k == 0 ? base : $urandom, $urandom, $urandom,
                              k == n - 1);
                    maybe_gap();
                end
                items += n;
            end else if (kind <= 5) begin
                send_beat(REQ_ERASE, $urandom_range(0, base),
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 6),
                          $urandom, $urandom);
                items++;
            end else if (kind == 6) begin
                send_beat(REQ_READ_ONE, $urandom_range(0, base), $urandom, $urandom, $urandom);
                items++;
            end else if (kind <= 8) begin
                send_beat(REQ_READ_RANGE, $urandom_range(0, base),
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 12),
                          $urandom, $urandom);
                items++;
            end else begin
                send_beat($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom);
                items++;
            end
            maybe_gap();
            if (items % 40 == 0) drain();
        end
        drain();
        if (errors == 0) $display("piece_table_text_buffer_core test passed");
        else $display("piece_table_text_buffer_core test failed");
        $finish;
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        int phase;
        phase = 0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 0;
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            phase++;
            m_tready <= (phase % 64 < 24) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    // result checker
    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending.size() == 0) begin
                report("unexpected beat", m_tdata, 0);
            end else begin
                e = pending.pop_front();
                if (m_tdata[7:0] != e.rbyte) report("read_byte", m_tdata[7:0], e.rbyte);
                if (m_tdata[9:8] != e.status) report("status", m_tdata[9:8], e.status);
                if (m_tdata[23:10] != e.dlen) report("doc_length", m_tdata[23:10], e.dlen);
                if (m_tdata[30:24] != e.npieces)
                    report("pieces_in_use", m_tdata[30:24], e.npieces);
                if (m_tlast != e.fin) report("tlast", m_tlast, e.fin);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= TimeoutCycles) begin
            $display("piece_table_text_buffer_core test failed");
            $finish;
        end
    end
endmodule

[filelist.f]
hw/rtl/pt_pkg.sv
hw/rtl/pt_ram.sv
hw/rtl/piece_table_text_buffer_core.sv
tb/tb.sv
